/* src/asg_pkg.sv */
package asg_pkg;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] chord_pitch;
  } in_item_t;

  typedef struct packed {
    logic [6:0] note_pitch;
    logic [6:0] note_velocity;
    logic       is_accent;
    logic       sequence_wrapped;
  } out_item_t;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_STEP  = 2'd3;

  localparam logic [2:0] REG_OCTAVE = 3'd0;
  localparam logic [2:0] REG_MODE   = 3'd1;
  localparam logic [2:0] REG_BASE   = 3'd2;
  localparam logic [2:0] REG_SPREAD = 3'd3;
  localparam logic [2:0] REG_ABITS  = 3'd4;
  localparam logic [2:0] REG_ALEN   = 3'd5;

  localparam logic [3:0] PAT_UP       = 4'd0;
  localparam logic [3:0] PAT_DOWN     = 4'd1;
  localparam logic [3:0] PAT_UPDOWN   = 4'd2;
  localparam logic [3:0] PAT_UPDOWNX  = 4'd3;
  localparam logic [3:0] PAT_DOWNUP   = 4'd4;
  localparam logic [3:0] PAT_RANDOM   = 4'd5;
  localparam logic [3:0] PAT_CHORD    = 4'd6;
  localparam logic [3:0] PAT_PINGPONG = 4'd7;
  localparam logic [3:0] PAT_CONVERGE = 4'd8;
  localparam logic [3:0] PAT_DIVERGE  = 4'd9;
  localparam logic [3:0] PAT_WALK     = 4'd10;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam int          WALK_MOVES = 15;

  function automatic logic [15:0] lfsr_next(input logic [15:0] s);
    lfsr_next = {s[0] ^ s[2] ^ s[3] ^ s[5], s[15:1]};
  endfunction

endpackage

/* src/arpeggio_step_generator_top.sv */
// Channel  Dir  Handshake             Payload
// in       in   in_valid/in_ready     in_item_t  {cmd, chord_pitch}
// out      out  out_valid/out_ready   out_item_t {note_pitch, note_velocity, is_accent,
//                                                 sequence_wrapped}
// cfg      in   cfg_we (no wait)      cfg_index, cfg_data
//
// One item at a time. Clear/add items are done in the accept state; a step item passes
// through accept, sequence read, registered velocity multiply and output load.
// Start: a read and a write state per chord read of the fill, an insertion sort of up
// to about n*n single-port pool accesses, then calc, read and write states per sequence
// entry; the pool memory port sets the pace (a full pool holds 32 notes).
// Reset (rst, sync) clears counts, positions and the LFSR; memories hold no reset.
// A step result waits in the out register; a following step stalls in its output
// load cycle, with in_ready low, until that result is taken.
module arpeggio_step_generator_top
  import asg_pkg::*;
#(
  parameter int MAX_CHORD_NOTES    = 8,
  parameter int MAX_OCTAVES        = 4,
  parameter int RANDOM_EXTRA_STEPS = 16,
  parameter int MAX_ACCENT_STEPS   = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int POOL_DEPTH = MAX_CHORD_NOTES * MAX_OCTAVES;
  localparam int SEQ_DEPTH  = 2 * POOL_DEPTH + RANDOM_EXTRA_STEPS + 16;
  localparam int CW = $clog2(MAX_CHORD_NOTES + 1);
  localparam int CA = (MAX_CHORD_NOTES > 1) ? $clog2(MAX_CHORD_NOTES) : 1;
  localparam int PW = $clog2(POOL_DEPTH + 1);
  localparam int PA = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int SW = $clog2(SEQ_DEPTH + 1);
  localparam int SA = $clog2(SEQ_DEPTH);
  localparam int OW = $clog2(MAX_OCTAVES + 1);
  localparam int AW = $clog2(MAX_ACCENT_STEPS + 1);
  localparam int EW = $clog2(POOL_DEPTH + RANDOM_EXTRA_STEPS + WALK_MOVES + 2);

  // configuration
  logic [OW-1:0] octave_span;
  logic [3:0]    pattern_mode;
  logic [6:0]    base_velocity;
  logic [6:0]    velocity_spread;
  logic [15:0]   accent_bits;
  logic [AW-1:0] accent_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_span     <= OW'(1);
      pattern_mode    <= PAT_UP;
      base_velocity   <= 7'd100;
      velocity_spread <= '0;
      accent_bits     <= '0;
      accent_length   <= AW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OCTAVE: begin
          if (cfg_data[2:0] == 3'd0) octave_span <= OW'(1);
          else if (32'(cfg_data[2:0]) > MAX_OCTAVES) octave_span <= OW'(MAX_OCTAVES);
          else octave_span <= OW'(cfg_data[2:0]);
        end
        REG_MODE:   pattern_mode <= cfg_data[3:0];
        REG_BASE: begin
          base_velocity <= (cfg_data[6:0] == 7'd0) ? 7'd1 : cfg_data[6:0];
        end
        REG_SPREAD: velocity_spread <= cfg_data[6:0];
        REG_ABITS:  accent_bits <= cfg_data;
        REG_ALEN: begin
          if (cfg_data[4:0] == 5'd0) accent_length <= AW'(1);
          else if (32'(cfg_data[4:0]) > MAX_ACCENT_STEPS)
            accent_length <= AW'(MAX_ACCENT_STEPS);
          else accent_length <= AW'(cfg_data[4:0]);
        end
        default: ;
      endcase
    end
  end

  // memories
  logic [6:0] chord_mem [MAX_CHORD_NOTES];
  logic [6:0] pool_mem  [POOL_DEPTH];
  logic [6:0] seq_mem   [SEQ_DEPTH];

  logic          chord_we;
  logic [CA-1:0] chord_waddr, chord_raddr;
  logic [6:0]    chord_wdata, chord_rdata;
  logic          pool_we;
  logic [PA-1:0] pool_addr;
  logic [6:0]    pool_wdata, pool_rdata;
  logic          seq_we;
  logic [SA-1:0] seq_waddr, seq_raddr;
  logic [6:0]    seq_wdata, seq_rdata;

  always_ff @(posedge clk) begin
    if (chord_we) chord_mem[chord_waddr] <= chord_wdata;
    chord_rdata <= chord_mem[chord_raddr];
  end

  always_ff @(posedge clk) begin
    if (pool_we) pool_mem[pool_addr] <= pool_wdata;
    pool_rdata <= pool_mem[pool_addr];
  end

  always_ff @(posedge clk) begin
    if (seq_we) seq_mem[seq_waddr] <= seq_wdata;
    seq_rdata <= seq_mem[seq_raddr];
  end

  typedef enum logic [4:0] {
    S_IDLE, S_FILL_RD, S_FILL_WR, S_SORT_RDV, S_SORT_RDJ, S_SORT_CMP, S_SORT_PUT,
    S_BLD_CALC, S_BLD_RD, S_BLD_WR, S_STP_RD, S_STP_MUL, S_STP_OUT
  } state_t;

  state_t        state;
  logic [CW-1:0] chord_count;
  logic [PW-1:0] pool_count;
  logic [SW-1:0] sequence_length;
  logic [SA-1:0] sequence_position;
  logic [AW-1:0] accent_position;
  logic [15:0]   random_state;

  // start-build working registers
  logic [OW-1:0] oct;
  logic [CW-1:0] ci;
  logic [PW-1:0] si, sj;
  logic [6:0]    sv;
  logic [EW-1:0] bi;       // build phase index
  logic          bphase;   // second half of two-run patterns
  logic [PW-1:0] wk;       // walk position
  logic [PA-1:0] bidx;
  logic          bdone;

  // step working registers
  logic signed [24:0] vprod;
  logic               acc;
  logic               wrapped;
  out_item_t          obuf;
  logic               ovalid;
  logic               obuf_load;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = ovalid;
  assign out_item  = obuf;

  // out register takes the step result once it is empty or being drained
  assign obuf_load = (state == S_STP_OUT) && (!ovalid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (obuf_load) ovalid <= 1'b1;
    else if (out_ready) ovalid <= 1'b0;
  end

  // pitch under fill: chord entry plus 12 per octave
  logic [8:0] fill_p;
  assign fill_p = 9'(chord_rdata) + 9'(oct) * 9'd12;

  // build address selection for entry bi of the sequence
  logic [PW-1:0] n, mid;
  logic [31:0]   rmul;
  logic [15:0]   rnd_next;
  assign n        = pool_count;
  assign mid      = n >> 1;
  assign rnd_next = lfsr_next(random_state);
  assign rmul     = 32'(rnd_next) * 32'(n);

  logic [PW:0]   sel;
  logic          sel_done;
  logic [PW-1:0] wk_next;
  always_comb begin
    logic [PW:0] ii;
    logic [PW:0] half;
    ii       = (PW+1)'(bi);
    half     = ii >> 1;
    sel      = '0;
    sel_done = 1'b0;
    wk_next  = wk;
    case (pattern_mode)
      PAT_DOWN: begin
        sel = (PW+1)'(n) - 1'b1 - ii;
        sel_done = (ii >= (PW+1)'(n));
      end
      PAT_UPDOWN, PAT_UPDOWNX, PAT_PINGPONG: begin
        if (!bphase) begin
          sel = ii;
        end else begin
          sel = (PW+1)'(n) - 2'd2 - ii;
          if (pattern_mode == PAT_UPDOWN)
            sel_done = (ii + 1'b1 >= (PW+1)'(n));
          else
            sel_done = (ii + 2'd2 >= (PW+1)'(n));
        end
      end
      PAT_DOWNUP: begin
        if (!bphase) sel = (PW+1)'(n) - 1'b1 - ii;
        else begin
          sel = ii + 1'b1;
          sel_done = (ii + 1'b1 >= (PW+1)'(n));
        end
      end
      PAT_RANDOM: begin
        if (!bphase) sel = ii;
        else begin
          sel = (rmul[15+PW:16] < n) ? (PW+1)'(rmul[15+PW:16]) : (PW+1)'(n) - 1'b1;
          sel_done = (32'(bi) >= RANDOM_EXTRA_STEPS);
        end
      end
      PAT_CHORD: begin
        sel = '0;
        sel_done = (bi != '0);
      end
      PAT_CONVERGE: begin
        sel = ii[0] ? (PW+1)'(n) - 1'b1 - half : half;
        sel_done = (ii >= (PW+1)'(n));
      end
      PAT_DIVERGE: begin
        // entry 0 is the centre, then lower/upper pairs
        if (ii == '0) sel = (PW+1)'(mid);
        else if (ii[0]) sel = (PW+1)'(mid) - ((ii + 1'b1) >> 1);
        else sel = (PW+1)'(mid) + (ii >> 1);
        sel_done = (ii >= (PW+1)'(n));
      end
      PAT_WALK: begin
        if (bi == '0) sel = '0;
        else begin
          if (rnd_next > 16'd32768) begin
            if ((PW+1)'(wk) + 1'b1 < (PW+1)'(n)) wk_next = wk + 1'b1;
          end else if (wk != '0) wk_next = wk - 1'b1;
          sel = (PW+1)'(wk_next);
        end
        sel_done = (32'(bi) > WALK_MOVES);
      end
      default: begin
        sel = ii;
        sel_done = (ii >= (PW+1)'(n));
      end
    endcase
  end

  // end of first run in two-run patterns
  logic run1_end;
  always_comb begin
    case (pattern_mode)
      PAT_UPDOWN, PAT_UPDOWNX, PAT_PINGPONG, PAT_DOWNUP, PAT_RANDOM:
        run1_end = !bphase && ((PW+1)'(bi) >= (PW+1)'(n));
      default: run1_end = 1'b0;
    endcase
  end

  logic draws;
  assign draws = (pattern_mode == PAT_RANDOM && bphase) ||
                 (pattern_mode == PAT_WALK && bi != '0);

  // velocity after multiply
  logic signed [25:0] vsum;
  logic [6:0]         vel, vel_acc;
  always_comb begin
    vsum = 26'(signed'({1'b0, base_velocity, 16'd0})) + 26'(vprod);
    if (vsum < 0) vel = 7'd0;
    else if (vsum[25:16] > 10'd127) vel = 7'd127;
    else vel = vsum[22:16];
    vel_acc = vel;
    if (acc) vel_acc = (8'(vel) + 8'd20 > 8'd127) ? 7'd127 : 7'(vel + 7'd20);
  end

  always_comb begin
    chord_we    = 1'b0;
    chord_waddr = chord_count[CA-1:0];
    chord_wdata = in_item.chord_pitch;
    chord_raddr = ci[CA-1:0];
    if (state == S_IDLE && in_valid && in_item.cmd == CMD_ADD &&
        32'(chord_count) < MAX_CHORD_NOTES)
      chord_we = 1'b1;
  end

  always_comb begin
    pool_we    = 1'b0;
    pool_wdata = fill_p[6:0];
    pool_addr  = pool_count[PA-1:0];
    case (state)
      S_FILL_WR: begin
        pool_we = (fill_p <= 9'd127) && (32'(pool_count) < POOL_DEPTH);
      end
      S_SORT_RDV: pool_addr = si[PA-1:0];
      S_SORT_RDJ: pool_addr = PA'(sj - 1'b1);
      S_SORT_CMP: begin
        pool_addr  = sj[PA-1:0];
        pool_wdata = pool_rdata;
        pool_we    = (pool_rdata > sv);
      end
      S_SORT_PUT: begin
        pool_addr  = sj[PA-1:0];
        pool_wdata = sv;
        pool_we    = 1'b1;
      end
      S_BLD_CALC: pool_addr = sel[PA-1:0];
      S_BLD_RD:   pool_addr = bidx;   // keep the picked entry on the read port
      default: ;
    endcase
  end

  assign seq_we    = (state == S_BLD_WR);
  assign seq_waddr = sequence_length[SA-1:0];
  assign seq_wdata = pool_rdata;
  assign seq_raddr = (32'(sequence_position) >= 32'(sequence_length)) ? '0 : sequence_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      chord_count       <= '0;
      pool_count        <= '0;
      sequence_length   <= '0;
      sequence_position <= '0;
      accent_position   <= '0;
      random_state      <= LFSR_SEED;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (in_item.cmd)
              CMD_CLEAR: chord_count <= '0;
              CMD_ADD: begin
                if (32'(chord_count) < MAX_CHORD_NOTES) chord_count <= chord_count + 1'b1;
              end
              CMD_START: begin
                pool_count <= '0;
                oct        <= '0;
                ci         <= '0;
                state      <= (chord_count == '0) ? S_SORT_RDV : S_FILL_RD;
                si         <= PW'(1);
              end
              default: begin
                if (sequence_length != '0) begin
                  if (32'(sequence_position) >= 32'(sequence_length))
                    sequence_position <= '0;
                  if (accent_position >= accent_length) accent_position <= '0;
                  state <= S_STP_RD;
                end
              end
            endcase
          end
        end
        // pool fill: chord entry ci read at octave oct
        S_FILL_RD: state <= S_FILL_WR;
        S_FILL_WR: begin
          if (pool_we) pool_count <= pool_count + 1'b1;
          if (ci + 1'b1 >= chord_count) begin
            ci <= '0;
            if (oct + 1'b1 >= octave_span) state <= S_SORT_RDV;
            else begin
              oct   <= oct + 1'b1;
              state <= S_FILL_RD;
            end
          end else begin
            ci    <= ci + 1'b1;
            state <= S_FILL_RD;
          end
        end
        // insertion sort, one pool access a cycle
        S_SORT_RDV: begin
          if (si >= pool_count) begin
            sequence_length   <= '0;
            sequence_position <= '0;
            accent_position   <= '0;
            bi     <= '0;
            bphase <= 1'b0;
            wk     <= '0;
            state  <= (pool_count == '0) ? S_IDLE : S_BLD_CALC;
          end else begin
            sj    <= si;
            state <= S_SORT_RDJ;
          end
        end
        S_SORT_RDJ: begin
          if (sj == si) sv <= pool_rdata;
          state <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (pool_rdata > sv) begin
            sj <= sj - 1'b1;
            state <= (sj == PW'(1)) ? S_SORT_PUT : S_SORT_RDJ;
          end else state <= S_SORT_PUT;
        end
        S_SORT_PUT: begin
          si    <= si + 1'b1;
          state <= S_SORT_RDV;
        end
        // sequence build: pick pool entry, read it, write it out
        S_BLD_CALC: begin
          if (run1_end) begin
            bphase <= 1'b1;
            bi     <= '0;
          end else if (sel_done || 32'(sequence_length) >= SEQ_DEPTH) begin
            state <= S_IDLE;
          end else begin
            if (draws) random_state <= rnd_next;
            wk    <= wk_next;
            bidx  <= sel[PA-1:0];
            bdone <= (pattern_mode == PAT_DIVERGE) && !(sel < (PW+1)'(n));
            state <= S_BLD_RD;
          end
        end
        S_BLD_RD: state <= bdone ? S_BLD_CALC : S_BLD_WR;
        S_BLD_WR: begin
          sequence_length <= sequence_length + 1'b1;
          bi    <= bi + 1'b1;
          state <= S_BLD_CALC;
        end
        // step: sequence read, then velocity multiply
        S_STP_RD: begin
          random_state <= rnd_next;
          vprod <= 25'(signed'({1'b0, rnd_next}) - 18'sd32768) *
                   25'(signed'({1'b0, velocity_spread}));
          acc <= (32'(accent_position) < 16) ? accent_bits[accent_position[3:0]] : 1'b0;
          wrapped <= (32'(sequence_position) + 1 == 32'(sequence_length));
          state <= S_STP_MUL;
        end
        S_STP_MUL: state <= S_STP_OUT;
        S_STP_OUT: begin
          if (obuf_load) begin
            obuf.note_pitch       <= seq_rdata;
            obuf.note_velocity    <= vel_acc;
            obuf.is_accent        <= acc;
            obuf.sequence_wrapped <= wrapped;
            sequence_position <= wrapped ? '0 : sequence_position + 1'b1;
            accent_position   <= (accent_position + 1'b1 >= accent_length) ? '0 :
                                 accent_position + 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    32'(chord_count) <= MAX_CHORD_NOTES) else $error("chord count overflow");
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pool_count) <= POOL_DEPTH) else $error("pool count overflow");
  a_seq_bound: assert property (@(posedge clk) disable iff (rst)
    32'(sequence_length) <= SEQ_DEPTH) else $error("sequence overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_lfsr_live: assert property (@(posedge clk) disable iff (rst)
    random_state != 16'd0) else $error("lfsr stuck");

endmodule

/* tb/tb_arpeggio_step_generator_top.sv */
`timescale 1ns / 100ps

module tb_arpeggio_step_generator_top;
  import asg_pkg::*;

  localparam int CHORD_DEPTH  = 8;
  localparam int OCT_MAX      = 4;
  localparam int EXTRA_RANDOM = 16;
  localparam int ACCENT_MAX   = 16;
  localparam int POOL_SIZE    = CHORD_DEPTH * OCT_MAX;
  localparam int SEQ_SIZE     = 2 * POOL_SIZE + EXTRA_RANDOM + 16;
  localparam int ITEM_TARGET  = 1750;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 2000;  // covers a full start build with no result

  // row kinds of the directed table
  localparam int ROW_PREDICT = 0;
  localparam int ROW_NOTE    = 1;
  localparam int ROW_SILENT  = 2;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  arpeggio_step_generator_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Arpeggiator predictor: private copy of settings and state
  // ---------------------------------------------------------------------------
  logic [2:0]  span_q;
  logic [3:0]  mode_q;
  logic [6:0]  base_q;
  logic [6:0]  spread_q;
  logic [15:0] abits_q;
  logic [4:0]  alen_q;

  logic [6:0]  chord_mem [CHORD_DEPTH];
  int          chord_n;
  logic [6:0]  pool_mem [POOL_SIZE];
  int          pool_n;
  logic [6:0]  seq_mem [SEQ_SIZE];
  int          seq_len;
  int          seq_pos;
  int          acc_pos;
  logic [15:0] lfsr_q;

  out_item_t   notes_due[$];   // expected notes, oldest first

  int  errors;
  int  notes_seen;
  int  items_sent;
  int  cycles;
  int  phases_run;
  bit  calm;       // no random idling on either side
  bit  hold_req;   // asks the receiver for one long stall

  // append a note at the tail of the due list
  function automatic void queue_note(out_item_t nt);
    notes_due = {notes_due, nt};
  endfunction

  function automatic logic [15:0] lfsr_advance();
    logic fb;
    fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
    lfsr_q = {fb, lfsr_q[15:1]};
    return lfsr_q;
  endfunction

  function automatic void seq_push(logic [6:0] p);
    if (seq_len < SEQ_SIZE) begin
      seq_mem[seq_len] = p;
      seq_len++;
    end
  endfunction

  // spread chord over octaves, sort, lay out the step pattern
  function automatic void build_sequence();
    int p, j, n, mid, k;
    logic [6:0] v;
    logic [15:0] r;
    pool_n = 0;
    for (int o = 0; o < span_q; o++) begin
      for (int i = 0; i < chord_n; i++) begin
        p = chord_mem[i] + 12 * o;
        if (p <= 127 && pool_n < POOL_SIZE) begin
          pool_mem[pool_n] = p[6:0];
          pool_n++;
        end
      end
    end
    for (int i = 1; i < pool_n; i++) begin
      v = pool_mem[i];
      j = i;
      while (j > 0 && pool_mem[j-1] > v) begin
        pool_mem[j] = pool_mem[j-1];
        j--;
      end
      pool_mem[j] = v;
    end
    n = pool_n;
    seq_len = 0;
    seq_pos = 0;
    acc_pos = 0;
    if (n == 0) return;
    case (mode_q)
      PAT_DOWN: begin
        for (int i = n; i > 0; i--) seq_push(pool_mem[i-1]);
      end
      PAT_UPDOWN: begin
        for (int i = 0; i < n; i++) seq_push(pool_mem[i]);
        for (int i = n - 1; i > 0; i--) seq_push(pool_mem[i-1]);
      end
      PAT_UPDOWNX, PAT_PINGPONG: begin
        for (int i = 0; i < n; i++) seq_push(pool_mem[i]);
        for (int i = n - 1; i > 1; i--) seq_push(pool_mem[i-1]);
      end
      PAT_DOWNUP: begin
        for (int i = n; i > 0; i--) seq_push(pool_mem[i-1]);
        for (int i = 1; i < n; i++) seq_push(pool_mem[i]);
      end
      PAT_RANDOM: begin
        for (int i = 0; i < n; i++) seq_push(pool_mem[i]);
        for (int i = 0; i < EXTRA_RANDOM; i++) begin
          r = lfsr_advance();
          k = (int'(r) * n) >>> 16;
          seq_push(pool_mem[k < n ? k : n - 1]);
        end
      end
      PAT_CHORD: seq_push(pool_mem[0]);
      PAT_CONVERGE: begin
        for (int i = 0; i < n; i++)
          seq_push(pool_mem[(i & 1) ? n - 1 - i / 2 : i / 2]);
      end
      PAT_DIVERGE: begin
        // centre note once, then pairs outward, lower side first
        mid = n / 2;
        seq_push(pool_mem[mid]);
        for (int o = 1; o <= mid; o++) begin
          seq_push(pool_mem[mid - o]);
          if (mid + o < n) seq_push(pool_mem[mid + o]);
        end
      end
      PAT_WALK: begin
        k = 0;
        seq_push(pool_mem[0]);
        for (int i = 0; i < WALK_MOVES; i++) begin
          r = lfsr_advance();
          if (r > 16'd32768) begin
            if (k + 1 < n) k++;
          end else if (k > 0) begin
            k--;
          end
          seq_push(pool_mem[k]);
        end
      end
      default: begin   // up, and modes 11..15
        for (int i = 0; i < n; i++) seq_push(pool_mem[i]);
      end
    endcase
  endfunction

  // one accepted item; returns 1 with the note when a step fires
  function automatic bit arp_apply(in_item_t it, output out_item_t note);
    int sv, vel;
    bit acc, wrap;
    note = '0;
    case (it.cmd)
      CMD_CLEAR: begin
        chord_n = 0;
        return 0;
      end
      CMD_ADD: begin
        if (chord_n < CHORD_DEPTH) begin
          chord_mem[chord_n] = it.chord_pitch;
          chord_n++;
        end
        return 0;
      end
      CMD_START: begin
        build_sequence();
        return 0;
      end
      default: begin
        if (seq_len == 0) return 0;
        if (seq_pos >= seq_len) seq_pos = 0;
        if (acc_pos >= alen_q) acc_pos = 0;
        sv = int'(base_q) * 65536 + (int'(lfsr_advance()) - 32768) * int'(spread_q);
        vel = sv < 0 ? 0 : (sv >>> 16);
        if (vel > 127) vel = 127;
        acc = (acc_pos < 16) ? abits_q[acc_pos] : 1'b0;
        if (acc) vel = (vel + 20 > 127) ? 127 : vel + 20;
        wrap = (seq_pos + 1 == seq_len);
        note.note_pitch       = seq_mem[seq_pos];
        note.note_velocity    = vel[6:0];
        note.is_accent        = acc;
        note.sequence_wrapped = wrap;
        seq_pos = wrap ? 0 : seq_pos + 1;
        acc_pos = (acc_pos + 1 >= alen_q) ? 0 : acc_pos + 1;
        return 1;
      end
    endcase
  endfunction

  // mirror of a register write, with the clamping the block applies
  function automatic void arp_setting(logic [2:0] idx, logic [15:0] d);
    case (idx)
      REG_OCTAVE: span_q   = (d[2:0] < 1) ? 3'd1 : (d[2:0] > OCT_MAX ? 3'(OCT_MAX) : d[2:0]);
      REG_MODE:   mode_q   = d[3:0];
      REG_BASE:   base_q   = (d[6:0] < 1) ? 7'd1 : d[6:0];
      REG_SPREAD: spread_q = d[6:0];
      REG_ABITS:  abits_q  = d;
      REG_ALEN:   alen_q   = (d[4:0] < 1) ? 5'd1 :
                             (d[4:0] > ACCENT_MAX ? 5'(ACCENT_MAX) : d[4:0]);
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle counter and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d notes still due", cycles, notes_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Note receiver: random ready, one long stall on request, field checks
  // ---------------------------------------------------------------------------
  int hold_left;

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      notes_seen++;
      if (notes_due.size() == 0) begin
        report_mismatch("unexpected note pitch", out_item.note_pitch, -1);
      end else begin
        want = notes_due.pop_front();
        if (out_item.note_pitch != want.note_pitch)
          report_mismatch("note_pitch", out_item.note_pitch, want.note_pitch);
        if (out_item.note_velocity != want.note_velocity)
          report_mismatch("note_velocity", out_item.note_velocity, want.note_velocity);
        if (out_item.is_accent != want.is_accent)
          report_mismatch("is_accent", out_item.is_accent, want.is_accent);
        if (out_item.sequence_wrapped != want.sequence_wrapped)
          report_mismatch("sequence_wrapped", out_item.sequence_wrapped,
                          want.sequence_wrapped);
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // offer one item, wait for the handshake, then maybe idle a while
  task automatic send_item(logic [1:0] c, logic [6:0] p, int kind = ROW_PREDICT,
                           out_item_t typed = '0);
    in_item_t it;
    out_item_t note;
    bit fired;
    it.cmd = c;
    it.chord_pitch = p;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    fired = arp_apply(it, note);
    if (kind == ROW_NOTE) queue_note(typed);
    else if (kind == ROW_PREDICT && fired) queue_note(note);
    items_sent++;
    if (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  // settings only change with the block idle
  task automatic drain();
    in_valid <= 1'b0;
    while (notes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_setting(logic [2:0] idx, logic [15:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    arp_setting(idx, d);
  endtask

  task automatic write_all(logic [15:0] oct, logic [15:0] md, logic [15:0] bv,
                           logic [15:0] sp, logic [15:0] ab, logic [15:0] al);
    write_setting(REG_OCTAVE, oct);
    write_setting(REG_MODE, md);
    write_setting(REG_BASE, bv);
    write_setting(REG_SPREAD, sp);
    write_setting(REG_ABITS, ab);
    write_setting(REG_ALEN, al);
    cfg_we <= 1'b0;
  endtask

  // pitch that often lands high, so upper octaves get dropped
  function automatic logic [6:0] pick_pitch();
    return ($urandom_range(3) == 0) ? 7'($urandom_range(127, 100)) : 7'($urandom_range(127));
  endfunction

  // clear, load a chord, start, then play a number of steps
  task automatic play_chord();
    int n, m;
    n = ($urandom_range(15) == 0) ? 0 : $urandom_range(10, 1);   // past 8 hits a full chord
    send_item(CMD_CLEAR, 7'($urandom_range(127)));
    for (int i = 0; i < n; i++) send_item(CMD_ADD, pick_pitch());
    send_item(CMD_START, 7'($urandom_range(127)));
    m = $urandom_range(40, 1);
    for (int i = 0; i < m; i++) begin
      // now and then clear mid-play; the old sequence must keep going
      if ($urandom_range(19) == 0) send_item(CMD_CLEAR, 7'($urandom_range(127)));
      send_item(CMD_STEP, 7'($urandom_range(127)));
    end
  endtask

  typedef struct {
    logic [1:0] c;
    logic [6:0] p;
    int         kind;
    out_item_t  typed;
  } drow_t;

  // directed table, reset settings: span 1, up, velocity 100, no spread or accent
  drow_t dtab[] = '{
    '{CMD_STEP,  7'd5,   ROW_SILENT,  '0},                    // nothing built yet
    '{CMD_ADD,   7'd67,  ROW_PREDICT, '0},
    '{CMD_ADD,   7'd60,  ROW_PREDICT, '0},
    '{CMD_ADD,   7'd64,  ROW_PREDICT, '0},
    '{CMD_START, 7'd0,   ROW_PREDICT, '0},
    '{CMD_STEP,  7'd0,   ROW_NOTE,    '{7'd60, 7'd100, 1'b0, 1'b0}},
    '{CMD_STEP,  7'd127, ROW_NOTE,    '{7'd64, 7'd100, 1'b0, 1'b0}},
    '{CMD_STEP,  7'd0,   ROW_NOTE,    '{7'd67, 7'd100, 1'b0, 1'b1}},
    '{CMD_STEP,  7'd0,   ROW_NOTE,    '{7'd60, 7'd100, 1'b0, 1'b0}},
    '{CMD_ADD,   7'd127, ROW_PREDICT, '0},
    '{CMD_ADD,   7'd0,   ROW_PREDICT, '0},
    '{CMD_START, 7'd127, ROW_PREDICT, '0},
    '{CMD_STEP,  7'd0,   ROW_NOTE,    '{7'd0, 7'd100, 1'b0, 1'b0}},
    '{CMD_STEP,  7'd0,   ROW_PREDICT, '0},
    '{CMD_CLEAR, 7'd127, ROW_PREDICT, '0},
    '{CMD_STEP,  7'd0,   ROW_PREDICT, '0},                    // still playing after clear
    '{CMD_STEP,  7'd0,   ROW_PREDICT, '0},
    '{CMD_START, 7'd0,   ROW_PREDICT, '0},                    // empty chord: empty sequence
    '{CMD_STEP,  7'd0,   ROW_SILENT,  '0},
    '{CMD_ADD,   7'd72,  ROW_PREDICT, '0},
    '{CMD_START, 7'd0,   ROW_PREDICT, '0},
    '{CMD_STEP,  7'd0,   ROW_NOTE,    '{7'd72, 7'd100, 1'b0, 1'b1}}
  };

  initial begin
    int p, budget;
    errors = 0; notes_seen = 0; items_sent = 0; cycles = 0; phases_run = 0;
    calm = 1'b0; hold_req = 1'b0; hold_left = 0;
    rst = 1'b1;
    in_valid = 1'b0; in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    span_q = 3'd1; mode_q = PAT_UP; base_q = 7'd100; spread_q = 7'd0;
    abits_q = 16'h0; alen_q = 5'd1;
    chord_n = 0; pool_n = 0; seq_len = 0; seq_pos = 0; acc_pos = 0;
    lfsr_q = LFSR_SEED;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dtab[i]) send_item(dtab[i].c, dtab[i].p, dtab[i].kind, dtab[i].typed);

    // phases: every pattern mode in turn, extremes first, then random settings
    p = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      case (p)
        0: write_all(16'd4, PAT_UP, 16'd127, 16'd127, 16'hFFFF, 16'd16);
        1: write_all(16'd0, PAT_DOWN, 16'd0, 16'd0, 16'h0000, 16'd0);
        2: write_all(16'd7, PAT_UPDOWN, 16'd1, 16'd127, 16'h8001, 16'd31);
        3: write_all(16'd1, PAT_UPDOWNX, 16'd127, 16'd0, 16'hAAAA, 16'd1);
        default: write_all(16'($urandom_range(7)), 16'(p % 16), 16'($urandom_range(127)),
                           16'($urandom_range(127)), 16'($urandom),
                           16'($urandom_range(31)));
      endcase
      phases_run++;
      // a few steps on the old sequence first: accent position meets the new length
      if ($urandom_range(1)) repeat ($urandom_range(5, 1)) send_item(CMD_STEP, 7'd0);
      budget = items_sent + 110;
      while (items_sent < budget) begin
        if ($urandom_range(9) < 8) play_chord();
        else send_item(2'($urandom_range(3)), 7'($urandom_range(127)));
      end
      // stall the receiver long while items keep coming in
      if (p == 5) begin
        hold_req = 1'b1;
        repeat (4) play_chord();
      end
      // stop sending until every note due is back
      if (p == 7) begin
        in_valid <= 1'b0;
        while (notes_due.size() != 0) @(posedge clk);
      end
      calm = (p >= 9 && p <= 10);   // a stretch with no idling on either side
      p++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (notes_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d items sent over %0d settings phases (all pattern modes, clamped extremes)",
             items_sent, phases_run);
    $display("%0d notes checked, %0d mismatches", notes_seen, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
